// File: rtl/spf_pkg.sv
package spf_pkg;

    localparam int RULE_DEPTH = 256;
    localparam int CONN_DEPTH = 1024;

    localparam int RAW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int RCW = $clog2(RULE_DEPTH + 1);
    localparam int CAW = (CONN_DEPTH > 1) ? $clog2(CONN_DEPTH) : 1;
    localparam int CCW = $clog2(CONN_DEPTH + 1);

    localparam int IN_W  = 136;
    localparam int OUT_W = 40;

    typedef enum logic [1:0] {
        OP_PKT  = 2'd0,
        OP_TICK = 2'd1,
        OP_INS  = 2'd2,
        OP_DEL  = 2'd3
    } op_t;

    localparam logic [1:0] KIND_DEFAULT = 2'd0;
    localparam logic [1:0] KIND_RULE    = 2'd1;
    localparam logic [1:0] KIND_CONN    = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_RULE_FULL = 2'd2;
    localparam logic [1:0] ST_CONN_FULL = 2'd3;

    localparam logic [1:0] ACT_PERMIT = 2'd0;
    localparam logic [1:0] ACT_REJECT = 2'd1;

    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    localparam logic [2:0] CLS_TCP  = 3'd0;
    localparam logic [2:0] CLS_UDP  = 3'd1;
    localparam logic [2:0] CLS_ICMP = 3'd2;
    localparam logic [2:0] CLS_ANY  = 3'b111;

    localparam logic [16:0] PORT_ANY = 17'h1FFFF;

    localparam logic CFG_DEFAULT_ACTION = 1'b0;
    localparam logic CFG_LIFETIME       = 1'b1;
    localparam logic [3:0] LIFETIME_RESET = 4'd5;

    typedef struct packed {
        op_t         op;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [16:0] src_port;
        logic [16:0] dst_port;
        logic [2:0]  cls;
        logic [8:0]  rule_index;
        logic [5:0]  src_shift;
        logic [5:0]  dst_shift;
        logic [2:0]  rule_protocol;
        logic [1:0]  rule_action;
    } cmd_t;

    typedef struct packed {
        logic [31:0] sa;
        logic [31:0] da;
        logic [5:0]  ssh;
        logic [5:0]  dsh;
        logic [16:0] sp;
        logic [16:0] dp;
        logic [2:0]  pr;
        logic [1:0]  act;
    } rule_t;

    typedef struct packed {
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
    } key_t;

    typedef struct packed {
        logic       default_action;
        logic [3:0] lifetime;
    } cfg_t;

    // first field in the highest bits
    typedef struct packed {
        logic [10:0] conn_count;
        logic [8:0]  rule_count;
        logic [1:0]  status;
        logic [7:0]  matched_rule;
        logic [1:0]  match_kind;
        logic        verdict;
    } result_t;

    function automatic logic [31:0] prefix_mask(input logic [5:0] sh);
        logic [31:0] m;
        if (sh >= 6'd32)
            m = '0;
        else
            m = 32'hFFFF_FFFF << sh;
        return m;
    endfunction

    function automatic logic port_ok(input logic [16:0] rp, input logic [15:0] pp);
        return (rp == PORT_ANY) || (!rp[16] && rp[15:0] == pp);
    endfunction

    function automatic logic rule_hit(input rule_t r, input cmd_t c);
        logic [31:0] sm;
        logic [31:0] dm;
        logic        hit;
        sm  = prefix_mask(r.ssh);
        dm  = prefix_mask(r.dsh);
        hit = (((r.sa ^ c.src_ip) & sm) == '0) && (((r.da ^ c.dst_ip) & dm) == '0)
              && (r.pr == CLS_ANY || r.pr == c.cls);
        if (c.cls != CLS_ICMP)
            hit = hit && port_ok(r.sp, c.src_port[15:0]) && port_ok(r.dp, c.dst_port[15:0]);
        return hit;
    endfunction

endpackage

// File: rtl/spf_front.sv
module spf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [spf_pkg::IN_W-1:0] s_tdata,
    output logic                 push,
    output spf_pkg::cmd_t        push_cmd,
    input  logic                 q_ready
);
    import spf_pkg::*;

    cmd_t in_reg, in_next;
    logic full_reg, full_next;
    logic accept;
    cmd_t dec;
    logic [7:0] proto;

    always_comb
    begin
        proto             = s_tdata[107:100];
        dec.op            = op_t'(s_tdata[1:0]);
        dec.src_ip        = s_tdata[33:2];
        dec.dst_ip        = s_tdata[65:34];
        dec.src_port      = s_tdata[82:66];
        dec.dst_port      = s_tdata[99:83];
        dec.rule_index    = s_tdata[116:108];
        dec.src_shift     = s_tdata[122:117];
        dec.dst_shift     = s_tdata[128:123];
        dec.rule_protocol = s_tdata[131:129];
        dec.rule_action   = s_tdata[133:132];
        case (proto)
            PROTO_TCP:  dec.cls = CLS_TCP;
            PROTO_UDP:  dec.cls = CLS_UDP;
            PROTO_ICMP: dec.cls = CLS_ICMP;
            default:    dec.cls = CLS_ANY;   // unknown protocol, matches nothing
        endcase
    end

    assign push     = full_reg && q_ready;
    assign push_cmd = in_reg;
    assign s_tready = !full_reg || q_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        in_next   = in_reg;
        full_next = full_reg;
        if (accept)
        begin
            in_next   = dec;
            full_next = 1'b1;
        end
        else if (push)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        in_reg <= in_next;
    end

endmodule

// File: rtl/spf_queue.sv
module spf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  spf_pkg::cmd_t din,
    output logic          ready,
    output logic          valid,
    output spf_pkg::cmd_t dout,
    input  logic          pop
);
    import spf_pkg::*;

    cmd_t       slot_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign ready = (cnt_reg != 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign dout  = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= din;
    end

endmodule

// File: rtl/spf_back.sv
module spf_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  spf_pkg::cfg_t             cfg,
    input  logic                      cmd_valid,
    input  spf_pkg::cmd_t             cmd,
    output logic                      cmd_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [spf_pkg::OUT_W-1:0] m_tdata
);
    import spf_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CSCAN = 8'b0000_0010,
        S_RSCAN = 8'b0000_0100,
        S_AGE   = 8'b0000_1000,
        S_SHUP  = 8'b0001_0000,
        S_INSWR = 8'b0010_0000,
        S_SHDN  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t  state_reg, state_next;
    cmd_t    cmd_reg, cmd_next;
    result_t res_reg, res_next;
    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    logic [RCW-1:0] rule_total_reg, rule_total_next;
    logic [CCW-1:0] conn_total_reg, conn_total_next;
    logic [RCW-1:0] rra_reg, rra_next;
    logic           rrv_reg, rrv_next;
    logic [RAW-1:0] rri_reg, rri_next;
    logic [CCW-1:0] cra_reg, cra_next;
    logic           crv_reg, crv_next;
    logic [CAW-1:0] cri_reg, cri_next;
    logic           rev_hit_reg, rev_hit_next;
    logic [CAW-1:0] rev_idx_reg, rev_idx_next;
    logic [CCW-1:0] wj_reg, wj_next;

    rule_t          rule_mem [RULE_DEPTH];
    rule_t          rule_q;
    logic           rule_re, rule_we;
    logic [RAW-1:0] rule_ra, rule_wa;
    rule_t          rule_wd;

    key_t           key_mem [CONN_DEPTH];
    logic [3:0]     life_mem [CONN_DEPTH];
    key_t           key_q;
    logic [3:0]     life_q;
    logic           conn_re, key_we, life_we;
    logic [CAW-1:0] conn_ra, key_wa, life_wa;
    key_t           key_wd;
    logic [3:0]     life_wd;

    key_t           fwd_key, rev_key;
    rule_t          new_rule;
    logic [RCW-1:0] rra_dec, rt_dec;

    assign fwd_key  = '{sa: cmd_reg.src_ip, da: cmd_reg.dst_ip,
                        sp: cmd_reg.src_port[15:0], dp: cmd_reg.dst_port[15:0]};
    assign rev_key  = '{sa: cmd_reg.dst_ip, da: cmd_reg.src_ip,
                        sp: cmd_reg.dst_port[15:0], dp: cmd_reg.src_port[15:0]};
    assign new_rule = '{sa: cmd_reg.src_ip, da: cmd_reg.dst_ip, ssh: cmd_reg.src_shift,
                        dsh: cmd_reg.dst_shift, sp: cmd_reg.src_port, dp: cmd_reg.dst_port,
                        pr: cmd_reg.rule_protocol, act: cmd_reg.rule_action};
    assign rra_dec  = rra_reg - 1'b1;
    assign rt_dec   = rule_total_reg - 1'b1;

    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, out_reg};

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        rule_total_next = rule_total_reg;
        conn_total_next = conn_total_reg;
        rra_next        = rra_reg;
        rrv_next        = 1'b0;
        rri_next        = rri_reg;
        cra_next        = cra_reg;
        crv_next        = 1'b0;
        cri_next        = cri_reg;
        rev_hit_next    = rev_hit_reg;
        rev_idx_next    = rev_idx_reg;
        wj_next         = wj_reg;
        rule_re = 1'b0;  rule_ra = '0;
        rule_we = 1'b0;  rule_wa = '0;  rule_wd = rule_q;
        conn_re = 1'b0;  conn_ra = '0;
        key_we  = 1'b0;  key_wa  = '0;  key_wd  = key_q;
        life_we = 1'b0;  life_wa = '0;  life_wd = cfg.lifetime;

        // conn table read issue, shared by lookup and aging
        if ((state_reg == S_CSCAN || state_reg == S_AGE) && cra_reg < conn_total_reg)
        begin
            conn_re  = 1'b1;
            conn_ra  = cra_reg[CAW-1:0];
            crv_next = 1'b1;
            cri_next = cra_reg[CAW-1:0];
            cra_next = cra_reg + 1'b1;
        end

        // rule table read issue
        if ((state_reg == S_RSCAN || state_reg == S_SHDN) && rra_reg < rule_total_reg)
        begin
            rule_re  = 1'b1;
            rule_ra  = rra_reg[RAW-1:0];
            rrv_next = 1'b1;
            rri_next = rra_reg[RAW-1:0];
            rra_next = rra_reg + 1'b1;
        end
        else if (state_reg == S_SHUP && rra_reg > RCW'(cmd_reg.rule_index))
        begin
            // walk down from the top so nothing is overwritten before it moves
            rule_re  = 1'b1;
            rule_ra  = rra_dec[RAW-1:0];
            rrv_next = 1'b1;
            rri_next = rra_dec[RAW-1:0];
            rra_next = rra_dec;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next     = cmd;
                    rev_hit_next = 1'b0;
                    res_next     = '0;
                    res_next.match_kind = KIND_NONE;
                    res_next.status     = ST_OK;
                    cra_next     = '0;
                    rra_next     = '0;
                    wj_next      = '0;
                    state_next   = S_DONE;
                    case (cmd.op)
                        OP_PKT:
                        begin
                            res_next.verdict    = cfg.default_action;
                            res_next.match_kind = KIND_DEFAULT;
                            if (rule_total_reg != '0 && cmd.cls == CLS_TCP
                                && conn_total_reg != '0)
                                state_next = S_CSCAN;
                            else if (rule_total_reg != '0 && cmd.cls != CLS_ANY)
                                state_next = S_RSCAN;
                        end
                        OP_TICK:
                        begin
                            if (conn_total_reg != '0)
                                state_next = S_AGE;
                        end
                        OP_INS:
                        begin
                            if (cmd.rule_index > rule_total_reg)
                                res_next.status = ST_BAD_INDEX;
                            else if (rule_total_reg >= RCW'(RULE_DEPTH))
                                res_next.status = ST_RULE_FULL;
                            else
                            begin
                                rra_next   = rule_total_reg;
                                state_next = (rule_total_reg > cmd.rule_index) ? S_SHUP
                                                                                : S_INSWR;
                            end
                        end
                        OP_DEL:
                        begin
                            if (cmd.rule_index >= rule_total_reg)
                                res_next.status = ST_BAD_INDEX;
                            else
                            begin
                                rra_next = RCW'(cmd.rule_index) + 1'b1;
                                if (RCW'(cmd.rule_index) + 1'b1 < rule_total_reg)
                                    state_next = S_SHDN;
                                else
                                    rule_total_next = rule_total_reg - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_CSCAN:
            begin
                if (crv_reg && key_q == fwd_key)
                begin
                    life_we = 1'b1;
                    life_wa = cri_reg;
                    res_next.verdict    = 1'b1;
                    res_next.match_kind = KIND_CONN;
                    state_next = S_DONE;
                end
                else if (crv_reg)
                begin
                    if (key_q == rev_key && !rev_hit_reg)
                    begin
                        rev_hit_next = 1'b1;
                        rev_idx_next = cri_reg;
                    end
                end
                else if (cra_reg >= conn_total_reg)
                begin
                    // forward search exhausted: reverse hit, else the rules
                    if (rev_hit_reg)
                    begin
                        life_we = 1'b1;
                        life_wa = rev_idx_reg;
                        res_next.verdict    = 1'b1;
                        res_next.match_kind = KIND_CONN;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rra_next   = '0;
                        state_next = S_RSCAN;
                    end
                end
            end

            S_RSCAN:
            begin
                if (rrv_reg && rule_hit(rule_q, cmd_reg))
                begin
                    res_next.match_kind   = KIND_RULE;
                    res_next.matched_rule = 8'(rri_reg);
                    res_next.verdict      = (rule_q.act != ACT_REJECT);
                    if (cmd_reg.cls == CLS_TCP && rule_q.act == ACT_PERMIT)
                    begin
                        if (conn_total_reg >= CCW'(CONN_DEPTH))
                            res_next.status = ST_CONN_FULL;
                        else
                        begin
                            key_we  = 1'b1;
                            key_wa  = conn_total_reg[CAW-1:0];
                            key_wd  = fwd_key;
                            life_we = 1'b1;
                            life_wa = conn_total_reg[CAW-1:0];
                            conn_total_next = conn_total_reg + 1'b1;
                        end
                    end
                    state_next = S_DONE;
                end
                else if (!rrv_reg && rra_reg >= rule_total_reg)
                    state_next = S_DONE;
            end

            S_AGE:
            begin
                if (crv_reg)
                begin
                    if (life_q > 4'd1)
                    begin
                        key_we  = 1'b1;
                        key_wa  = wj_reg[CAW-1:0];
                        key_wd  = key_q;
                        life_we = 1'b1;
                        life_wa = wj_reg[CAW-1:0];
                        life_wd = life_q - 4'd1;
                        wj_next = wj_reg + 1'b1;
                    end
                end
                else if (cra_reg >= conn_total_reg)
                begin
                    conn_total_next = wj_reg;
                    state_next      = S_DONE;
                end
            end

            S_SHUP:
            begin
                if (rrv_reg)
                begin
                    rule_we = 1'b1;
                    rule_wa = rri_reg + 1'b1;
                    rule_wd = rule_q;
                    if (rri_reg == RAW'(cmd_reg.rule_index))
                        state_next = S_INSWR;
                end
            end

            S_INSWR:
            begin
                rule_we = 1'b1;
                rule_wa = RAW'(cmd_reg.rule_index);
                rule_wd = new_rule;
                rule_total_next = rule_total_reg + 1'b1;
                state_next = S_DONE;
            end

            S_SHDN:
            begin
                if (rrv_reg)
                begin
                    rule_we = 1'b1;
                    rule_wa = rri_reg - 1'b1;
                    rule_wd = rule_q;
                    if (RCW'(rri_reg) == rt_dec)
                    begin
                        rule_total_next = rt_dec;
                        state_next      = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next            = res_reg;
                    out_next.rule_count = 9'(rule_total_reg);
                    out_next.conn_count = 11'(conn_total_reg);
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            rule_total_reg <= '0;
            conn_total_reg <= '0;
            rrv_reg        <= 1'b0;
            crv_reg        <= 1'b0;
            rev_hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            rule_total_reg <= rule_total_next;
            conn_total_reg <= conn_total_next;
            rrv_reg        <= rrv_next;
            crv_reg        <= crv_next;
            rev_hit_reg    <= rev_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        rra_reg     <= rra_next;
        rri_reg     <= rri_next;
        cra_reg     <= cra_next;
        cri_reg     <= cri_next;
        rev_idx_reg <= rev_idx_next;
        wj_reg      <= wj_next;
    end

    always_ff @(posedge clk)
    begin
        if (rule_re)
            rule_q <= rule_mem[rule_ra];
        if (rule_we)
            rule_mem[rule_wa] <= rule_wd;
    end

    always_ff @(posedge clk)
    begin
        if (conn_re)
            key_q <= key_mem[conn_ra];
        if (key_we)
            key_mem[key_wa] <= key_wd;
    end

    always_ff @(posedge clk)
    begin
        if (conn_re)
            life_q <= life_mem[conn_ra];
        if (life_we)
            life_mem[life_wa] <= life_wd;
    end

    a_rule_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rule_total_reg <= RCW'(RULE_DEPTH))
        else $error("rule count above depth");

    a_conn_bound: assert property (@(posedge clk) disable iff (!rst_n)
        conn_total_reg <= CCW'(CONN_DEPTH))
        else $error("connection count above depth");

    a_rule_step: assert property (@(posedge clk) disable iff (!rst_n)
        rule_total_reg != $past(rule_total_reg) |->
            (rule_total_reg == $past(rule_total_reg) + 1'b1
             || rule_total_reg == $past(rule_total_reg) - 1'b1))
        else $error("rule count moved by more than one");

    a_conn_grow: assert property (@(posedge clk) disable iff (!rst_n)
        conn_total_reg > $past(conn_total_reg) |->
            conn_total_reg == $past(conn_total_reg) + 1'b1)
        else $error("connection count grew by more than one");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg != S_IDLE))
        else $error("popped word not taken up");

endmodule

// File: rtl/stateful_packet_filter.sv
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: one operation word
// m_*       out  m_tvalid/m_tready  m_tdata: one result word per operation
// cfg_*     in   cfg_we             cfg_addr selects register, cfg_data
//
// Words run one at a time through the back engine; a word reaches it by way of
// the front register and the queue. The engine pops each word and ends with the
// result. In between, a TCP packet walks the n connection entries and, on a miss,
// a packet scans the rules until one hits; a tick walks the connection table; an
// insert moves k rules up before its write, and a delete moves later rules down.
// A held result stalls the engine in its final state. No clearing pass after reset.
// A two-word queue lets the front keep taking words while the back stalls.
module stateful_packet_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // opcode, src_ip, dst_ip, src_port, dst_port, ip_protocol, rule_index,
    // src_prefix_shift, dst_prefix_shift, rule_protocol, rule_action
    input  logic [spf_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // verdict, match_kind, matched_rule, status, rule_count, conn_count
    output logic [spf_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [3:0]                    cfg_data
);
    import spf_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic push, q_ready, q_valid, q_pop;
    cmd_t push_cmd, q_cmd;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DEFAULT_ACTION: cfg_next.default_action = cfg_data[0];
                CFG_LIFETIME:       cfg_next.lifetime       = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.default_action <= 1'b0;
            cfg_reg.lifetime       <= LIFETIME_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    spf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready)
    );

    spf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_cmd),
        .ready (q_ready),
        .valid (q_valid),
        .dout  (q_cmd),
        .pop   (q_pop)
    );

    spf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
